>>> src/awss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awss_pkg: shared types and constants
// Item types, opcodes, register indexes and the controller/datapath link.
// ----------------------------------------------------------------------------
package awss_pkg;

  localparam int DelayW = 32;
  localparam int PrioW  = 16;
  localparam int RepW   = 6;
  localparam int CntW   = 16;
  localparam int IdxW   = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam logic [0:0] REG_TICKS = 1'b0;
  localparam logic [0:0] REG_TOTAL = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [IdxW-1:0]   entry_index;
    logic [DelayW-1:0] start_delay;
    logic [DelayW-1:0] end_cap;
    logic [DelayW-1:0] min_interval;
    logic [PrioW-1:0]  entry_priority;
    logic [RepW-1:0]   repeat_count;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   chosen_entry;
    logic [DelayW-1:0] slot_time;
    logic              has_frame;
    logic              all_done;
    logic              last_of_run;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic start;
    logic scan_init;
    logic scan_step;
    logic mul_step;
    logic emit;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
    logic scan_last;
    logic found;
    logic run_more;
  } dp_stat_t;

endpackage

>>> src/awss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awss_datapath: entry tables, scan and slot generation
// Holds the entry tables, scans entries one by one through a single
// multiplier and generates slot times for the winning run.
// ----------------------------------------------------------------------------
module awss_datapath import awss_pkg::*; #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_REPEAT  = 63
) (
  input  logic            clk,
  input  logic            rst,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  input  in_item_t        item,
  input  logic [CntW-1:0] ticks_per_frame,
  input  logic [CntW-1:0] total_frames,
  output out_item_t       result
);

  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int WW = DelayW + PrioW;
  localparam logic [RepW-1:0] RepMax = RepW'(MAX_REPEAT);

  logic [NUM_ENTRIES-1:0] entry_valid;
  logic [DelayW-1:0] delay_table    [NUM_ENTRIES];
  logic [DelayW-1:0] cap_table      [NUM_ENTRIES];
  logic [DelayW-1:0] interval_table [NUM_ENTRIES];
  logic [PrioW-1:0]  priority_table [NUM_ENTRIES];
  logic [RepW-1:0]   repeat_table   [NUM_ENTRIES];
  logic [DelayW-1:0] last_use_time  [NUM_ENTRIES];

  logic [CntW-1:0]   slot_counter;
  logic [DelayW-1:0] now;
  logic [DelayW-1:0] now_prod;
  logic [EW-1:0]     scan_idx;
  logic              cand_ok;
  logic [DelayW-1:0] cand_diff;
  logic [PrioW-1:0]  cand_prio;
  logic [WW-1:0]     cand_weight;
  logic              found;
  logic [EW-1:0]     best;
  logic [WW-1:0]     best_weight;
  logic [PrioW-1:0]  best_prio;
  logic [RepW:0]     run_left;

  logic [DelayW-1:0] d_rd, c_rd, i_rd, l_rd;
  logic              elig;
  logic [DelayW-1:0] diff;
  logic              better;
  logic [RepW-1:0]   rep_sat;
  logic [CntW-1:0]   cnt_inc;

  assign now_prod = DelayW'(slot_counter) * DelayW'(ticks_per_frame);
  assign d_rd = delay_table[scan_idx];
  assign c_rd = cap_table[scan_idx];
  assign i_rd = interval_table[scan_idx];
  assign l_rd = last_use_time[scan_idx];
  assign diff = now - l_rd;
  assign elig = entry_valid[scan_idx] && (now >= d_rd) &&
                !(c_rd != '0 && now > c_rd) && (diff >= i_rd);
  assign better = !found || cand_weight > best_weight ||
                  (cand_weight == best_weight && cand_prio > best_prio);
  assign rep_sat = (item.repeat_count > RepMax) ? RepMax : item.repeat_count;
  assign cnt_inc = slot_counter + CntW'(1);

  assign stat.done      = slot_counter >= total_frames;
  assign stat.scan_last = scan_idx == EW'(NUM_ENTRIES - 1);
  assign stat.found     = found;
  assign stat.run_more  = (run_left > 1) && (cnt_inc < total_frames);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      slot_counter <= '0;
      for (int k = 0; k < NUM_ENTRIES; k++) last_use_time[k] <= '0;
    end else begin
      if (cmd.load && int'(item.entry_index) < NUM_ENTRIES) begin
        entry_valid[EW'(item.entry_index)]    <= 1'b1;
        delay_table[EW'(item.entry_index)]    <= item.start_delay;
        cap_table[EW'(item.entry_index)]      <= item.end_cap;
        interval_table[EW'(item.entry_index)] <= item.min_interval;
        priority_table[EW'(item.entry_index)] <= item.entry_priority;
        repeat_table[EW'(item.entry_index)]   <= rep_sat;
      end
      if (cmd.start) begin
        slot_counter <= '0;
        for (int k = 0; k < NUM_ENTRIES; k++) last_use_time[k] <= '0;
      end
      if (cmd.emit) slot_counter <= cnt_inc;
      if (cmd.commit && found) last_use_time[best] <= now_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      now      <= now_prod;
      scan_idx <= '0;
      found    <= 1'b0;
      cand_ok  <= 1'b0;
    end
    if (cmd.scan_step) begin
      cand_ok   <= elig;
      cand_diff <= diff;
      cand_prio <= priority_table[scan_idx];
    end
    if (cmd.mul_step) begin
      if (cand_ok && better) begin
        found       <= 1'b1;
        best        <= scan_idx;
        best_weight <= cand_weight;
        best_prio   <= cand_prio;
        run_left    <= {1'b0, repeat_table[scan_idx]} + (RepW+1)'(1);
      end
      scan_idx <= scan_idx + EW'(1);
    end
    if (cmd.emit) begin
      run_left  <= run_left - (RepW+1)'(1);
    end
  end

  assign cand_weight = WW'(cand_diff) * WW'(cand_prio);

  always_comb begin
    result.chosen_entry = found ? IdxW'(best) : '0;
    result.slot_time    = stat.done ? '0 : now_prod;
    result.has_frame    = found && !stat.done;
    result.all_done     = stat.done;
    result.last_of_run  = stat.done || !found || !stat.run_more;
  end

endmodule

>>> src/awss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awss_ctrl: sequencing controller
// Decodes items, walks the scan and issues one slot per output handshake.
// ----------------------------------------------------------------------------
module awss_ctrl import awss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [1:0] opcode,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     out_valid,
  input  logic     out_stall
);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_READ, S_MUL, S_EMIT} state_t;
  state_t state;
  logic   in_acc, out_acc;

  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_valid = state == S_EMIT;

  always_comb begin
    cmd = '0;
    cmd.load      = in_acc && opcode == OP_LOAD;
    cmd.start     = in_acc && opcode == OP_START;
    cmd.scan_init = state == S_INIT;
    cmd.scan_step = state == S_READ;
    cmd.mul_step  = state == S_MUL;
    cmd.emit      = out_acc && !stat.done && stat.found;
    cmd.commit    = out_acc && !stat.run_more;
    if (out_acc && !stat.done && !stat.found) cmd.emit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_acc && opcode == OP_STEP) state <= S_INIT;
        S_INIT: begin
          state <= stat.done ? S_EMIT : S_READ;
        end
        S_READ: state <= S_MUL;
        S_MUL:  state <= stat.scan_last ? S_EMIT : S_READ;
        S_EMIT: begin
          if (out_acc && (stat.done || !stat.found || !stat.run_more)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_only_when_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_acc) else $error("emit without handshake");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_acc) else $error("item taken while busy");
  a_scan_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_MUL)) else $error("scan order broken");

endmodule

>>> src/aging_weighted_slot_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_weighted_slot_scheduler_unit: weighted slot scheduler, top level
// Items arrive on in_valid/in_stall with an in_item_t payload. Load and
// start give no result. A step scans the entry table (one table read and
// one multiply per entry through a single multiplier), then gives 1 to
// MAX_REPEAT+1 results on out_valid/out_stall, one per cycle while the
// receiver does not stall.
// The output payload holds while out_stall is high; no item is taken
// until the last result of a step has been delivered.
// Registers: ticks_per_frame at 0x0 (reset 1), total_frames at 0x4
// (reset 0). rst is synchronous; it clears valid bits, last-use times, the
// slot counter and the controller. pready is always high.
// ----------------------------------------------------------------------------
module aging_weighted_slot_scheduler_unit import awss_pkg::*; #(
  parameter int NUM_ENTRIES = 16,
  parameter int MAX_REPEAT  = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CntW-1:0] ticks_per_frame, total_frames;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_frame <= CntW'(1);
      total_frames    <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_TICKS) ticks_per_frame <= pwdata[CntW-1:0];
      else total_frames <= pwdata[CntW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TICKS) ? {16'h0, ticks_per_frame}
                                           : {16'h0, total_frames};

  awss_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .opcode(in_item.opcode),
    .stat, .cmd, .out_valid, .out_stall
  );

  awss_datapath #(.NUM_ENTRIES(NUM_ENTRIES), .MAX_REPEAT(MAX_REPEAT)) u_dp (
    .clk, .rst, .cmd, .stat, .item(in_item), .ticks_per_frame, .total_frames,
    .result(out_item)
  );

endmodule

>>> tb/sv/aging_weighted_slot_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_weighted_slot_scheduler_unit_test: self-checking bench
// Loads table entries, starts and steps the schedule under several register
// settings and idling phases; a local model of the scheduler predicts every
// slot and the monitor compares each delivered slot with the oldest one.
// ----------------------------------------------------------------------------
module aging_weighted_slot_scheduler_unit_test;
  import awss_pkg::*;

  localparam int InW = $bits(in_item_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  aging_weighted_slot_scheduler_unit DUT (.*);

  // scheduler state mirror
  logic [15:0] tick_rate;
  logic [15:0] frame_limit;
  logic        ent_used [16];
  logic [31:0] ent_delay [16];
  logic [31:0] ent_cap [16];
  logic [31:0] ent_gap [16];
  logic [15:0] ent_prio [16];
  logic [5:0]  ent_rep [16];
  logic [31:0] ent_last [16];
  logic [15:0] frame_count;

  in_item_t  pending_items [$];
  out_item_t slots_due [$];
  int        errors = 0;
  int        cycle = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        hold_cycles = 0;
  bit        send_gate = 1'b1;

  function automatic out_item_t mk_slot(logic [3:0] e, logic [31:0] t, logic f,
                                        logic d, logic l);
    out_item_t r;
    r.chosen_entry = e; r.slot_time = t; r.has_frame = f;
    r.all_done = d; r.last_of_run = l;
    return r;
  endfunction

  task automatic schedule_item(in_item_t it);
    logic [31:0] now, diff, t;
    logic [47:0] w, best_w;
    logic [15:0] best_p;
    logic [3:0]  best;
    bit          found;
    int          j;
    now = 32'(frame_count) * 32'(tick_rate);
    found = 1'b0; best = '0; best_w = '0; best_p = '0; t = now;
    case (opcode_t'(it.opcode))
      OP_LOAD: begin
        ent_used[it.entry_index] = 1'b1;
        ent_delay[it.entry_index] = it.start_delay;
        ent_cap[it.entry_index] = it.end_cap;
        ent_gap[it.entry_index] = it.min_interval;
        ent_prio[it.entry_index] = it.entry_priority;
        ent_rep[it.entry_index] = it.repeat_count;
      end
      OP_START: begin
        frame_count = '0;
        foreach (ent_last[n]) ent_last[n] = '0;
      end
      OP_STEP: begin
        if (frame_count >= frame_limit) begin
          slots_due.push_back(mk_slot('0, '0, 1'b0, 1'b1, 1'b1));
        end else begin
          for (int n = 0; n < 16; n++) begin
            diff = now - ent_last[n];
            w = 48'(diff) * 48'(ent_prio[n]);
            if (ent_used[n] && now >= ent_delay[n] && !(ent_cap[n] != 0 && now > ent_cap[n])
                && diff >= ent_gap[n]) begin
              if (!found || w > best_w || (w == best_w && ent_prio[n] > best_p)) begin
                found = 1'b1; best = 4'(n); best_w = w; best_p = ent_prio[n];
              end
            end
          end
          if (!found) begin
            slots_due.push_back(mk_slot('0, now, 1'b0, 1'b0, 1'b1));
            frame_count++;
          end else begin
            j = 0;
            while (j <= ent_rep[best] && frame_count < frame_limit) begin
              t = 32'(frame_count) * 32'(tick_rate);
              slots_due.push_back(mk_slot(best, t, 1'b1, 1'b0, 1'b0));
              frame_count++;
              j++;
            end
            ent_last[best] = t;
            slots_due[$].last_of_run = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 1500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        schedule_item(in_item);
        void'(pending_items.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (send_gate && pending_items.size() > (in_valid && !in_stall ? 0 : 0)
                   && $urandom_range(99) >= send_idle && pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_item <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_slot;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (slots_due.size() == 0) begin
          errors++;
          $display("%0t unexpected slot actual %p", $time, out_item);
        end else begin
          exp_slot = slots_due.pop_front();
          if (out_item !== exp_slot) begin
            errors++;
            $display("%0t slot mismatch expected %p actual %p", $time, exp_slot, out_item);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  task automatic reg_write(logic [2:0] a, logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == 3'(4 * REG_TICKS)) tick_rate = v;
    else frame_limit = v;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || slots_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t mk_load(logic [3:0] idx, logic [31:0] dl, logic [31:0] cp,
                                       logic [31:0] gp, logic [15:0] pr, logic [5:0] rp);
    in_item_t it;
    it.opcode = OP_LOAD; it.entry_index = idx; it.start_delay = dl; it.end_cap = cp;
    it.min_interval = gp; it.entry_priority = pr; it.repeat_count = rp;
    return it;
  endfunction

  function automatic in_item_t mk_op(opcode_t op);
    in_item_t it;
    it = in_item_t'(InW'({$urandom, $urandom, $urandom, $urandom}));
    it.opcode = op;
    return it;
  endfunction

  function automatic logic [31:0] rnd_time();
    case ($urandom_range(3))
      0: return $urandom_range(40);
      1: return $urandom_range(2000);
      2: return 32'hFFFF_FFFF - $urandom_range(5);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 30)
        pending_items.push_back(mk_load(4'($urandom), $urandom_range(3) == 0 ? rnd_time() :
            $urandom_range(50), $urandom_range(2) == 0 ? 32'd0 : rnd_time(),
            $urandom_range(2) == 0 ? $urandom_range(20) : rnd_time(), 16'($urandom),
            $urandom_range(4) == 0 ? 6'($urandom) : 6'($urandom_range(3))));
      else if (r < 36) pending_items.push_back(mk_op(OP_START));
      else if (r < 39) pending_items.push_back(mk_op(OP_NONE));
      else pending_items.push_back(mk_op(OP_STEP));
    end
  endtask

  initial begin
    int phase_idle [4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{14, 14}};
    int ticks_set [4] = '{1, 65535, 0, 7};
    int total_set [4] = '{40, 65535, 0, 300};
    tick_rate = 16'd1; frame_limit = '0; frame_count = '0;
    foreach (ent_used[n]) begin
      ent_used[n] = 1'b0; ent_delay[n] = '0; ent_cap[n] = '0; ent_gap[n] = '0;
      ent_prio[n] = '0; ent_rep[n] = '0; ent_last[n] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // directed: empty table, done state, extremes
    pending_items.push_back(mk_op(OP_STEP));
    pending_items.push_back(mk_op(OP_NONE));
    wait_idle();
    reg_write(3'(4 * REG_TOTAL), 16'd200);
    reg_write(3'(4 * REG_TICKS), 16'd3);
    pending_items.push_back(mk_op(OP_STEP));
    pending_items.push_back(mk_load(4'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF, 6'd63));
    pending_items.push_back(mk_load(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    16'd0, 6'd0));
    pending_items.push_back(mk_load(4'd5, 32'd6, 32'd30, 32'd0, 16'h0100, 6'd2));
    pending_items.push_back(mk_load(4'd6, 32'd6, 32'd30, 32'd0, 16'h0100, 6'd2));
    pending_items.push_back(mk_op(OP_STEP));
    pending_items.push_back(mk_op(OP_START));
    pending_items.push_back(mk_load(4'd0, 32'd1000, 32'd0, 32'd0, 16'h0080, 6'd1));
    pending_items.push_back(mk_load(4'd3, 32'd3, 32'd0, 32'd9, 16'h8000, 6'd0));
    for (int k = 0; k < 8; k++) pending_items.push_back(mk_op(OP_STEP));
    pending_items.push_back(mk_op(OP_START));
    pending_items.push_back(mk_op(OP_STEP));
    wait_idle();
    reg_write(3'(4 * REG_TOTAL), 16'd2);
    pending_items.push_back(mk_op(OP_START));
    pending_items.push_back(mk_load(4'd9, 32'd0, 32'd0, 32'd0, 16'h0001, 6'd63));
    pending_items.push_back(mk_op(OP_STEP));
    pending_items.push_back(mk_op(OP_STEP));
    wait_idle();
    for (int p = 0; p < 4; p++) begin
      reg_write(3'(4 * REG_TICKS), 16'(ticks_set[p]));
      reg_write(3'(4 * REG_TOTAL), 16'(total_set[p]));
      send_idle = phase_idle[p][0];
      recv_idle = phase_idle[p][1];
      pending_items.push_back(mk_op(OP_START));
      add_random(42);
      if (p == 1) begin
        hold_cycles = 400;
        add_random(10);
      end
      wait_idle();
      if (p == 2) begin
        send_gate = 1'b0;
        add_random(5);
        while (slots_due.size() != 0) @(posedge clk);
        send_gate = 1'b1;
        wait_idle();
      end
    end
    send_idle = 0; recv_idle = 0;
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
